// ===== design/kmeans_1d_clusterer_assert.svh =====
// Assertion macros for the 1-D k-means clusterer, clocked on clk, disabled in reset.
`ifndef KMEANS_1D_CLUSTERER_ASSERT_SVH
`define KMEANS_1D_CLUSTERER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define KMC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked at every clock edge out of reset
`define KMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/kmc_pkg.sv =====
// Shared types and constants of the 1-D k-means clusterer.
package kmc_pkg;

	localparam int SAMPLE_W = 24;
	localparam int FRAC_W   = 8;
	localparam int CENT_W   = SAMPLE_W + FRAC_W;
	localparam int EW       = CENT_W + 1;
	localparam int TAG_W    = 4;
	localparam int STATUS_W = 2;
	localparam int ITER_W   = 8;
	localparam int NC_W     = 5;
	localparam int ME_W     = 32;
	localparam int MI_W     = 8;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;
	localparam int RIDX_W   = 2;

	localparam logic [RIDX_W-1:0] REG_NUM_CLUSTERS = 2'd0;
	localparam logic [RIDX_W-1:0] REG_MAX_ERROR    = 2'd1;
	localparam logic [RIDX_W-1:0] REG_MAX_ITERS    = 2'd2;

	localparam logic [NC_W-1:0] NC_RESET = 5'd2;
	localparam logic [ME_W-1:0] ME_RESET = 32'd0;
	localparam logic [MI_W-1:0] MI_RESET = 8'd16;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TOO_FEW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_MM_A,
		ST_MM_D,
		ST_SEED,
		ST_SEED_W,
		ST_ASG_A,
		ST_ASG_L,
		ST_ASG_C,
		ST_CLR,
		ST_SUM_A,
		ST_SUM_D,
		ST_MEAN,
		ST_MEAN_W,
		ST_CHK,
		ST_DEC,
		ST_OUT_A,
		ST_OUT_L,
		ST_FEW
	} st_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// ===== design/kmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/kmc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module kmc_div #(
	parameter int DW = 40,
	parameter int VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      rs;
	logic             ge;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		rs = {rem_q, quo_q[DW-1]};
		ge = (rs >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(rs - {1'b0, dvs_q}) : VW'(rs);
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/kmeans_1d_clusterer.sv =====
// Top level of the 1-D k-means clusterer: register port, sequencer and datapath.
//
// Samples are taken one per cycle into a sample RAM; the sample that carries is_last
// starts a run, during which item_ready is low. A run does a min/max scan, seeding
// and a first assignment, then per iteration the sums, the means and a relocation
// pass. Seeding and means use the shared bit-serial divider, whose dividend is
// DW = 32 + log2 of the larger parameter (38 by default) bits wide. Distances use one
// shared subtract-and-compare unit, one centroid per cycle. Tags then leave one at a
// time through an output register, each held until the previous result is taken;
// the block takes new samples while the final result of a run still waits. A run of
// fewer than two samples gives one result with status too_few.
module kmeans_1d_clusterer #(
	parameter int MAX_POINTS   = 64,
	parameter int MAX_CLUSTERS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [kmc_pkg::ADDR_W-1:0]      paddr,
	input  logic [kmc_pkg::DATA_W-1:0]      pwdata,
	output logic [kmc_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic signed [kmc_pkg::SAMPLE_W-1:0] sample,
	input  logic                            is_last,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [kmc_pkg::TAG_W-1:0]       tag,
	output logic [kmc_pkg::STATUS_W-1:0]    status,
	output logic [kmc_pkg::ITER_W-1:0]      iterations,
	output logic                            last_tag
);
	import kmc_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int NW = IW + 1;
	localparam int KW = CW + 1;
	localparam int SW = SAMPLE_W + NW;
	localparam int TW = EW + NW;
	localparam int VW = (NW > KW) ? NW : KW;
	localparam int DW = CENT_W + ((IW > CW) ? IW : CW);

	// configuration registers
	logic [NC_W-1:0] nc_q;
	logic [ME_W-1:0] me_q;
	logic [MI_W-1:0] mi_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= NC_RESET;
			me_q <= ME_RESET;
			mi_q <= MI_RESET;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_NUM_CLUSTERS: nc_q <= pwdata[NC_W-1:0];
				REG_MAX_ERROR:    me_q <= pwdata[ME_W-1:0];
				REG_MAX_ITERS:    mi_q <= pwdata[MI_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_NUM_CLUSTERS: prdata = DATA_W'(nc_q);
			REG_MAX_ERROR:    prdata = DATA_W'(me_q);
			REG_MAX_ITERS:    prdata = DATA_W'(mi_q);
			default:          prdata = '0;
		endcase
	end

	// state and datapath registers
	st_t st_q, st_d;
	logic [NW-1:0]               cnt_q;
	logic                        ovf_q;
	logic [NW-1:0]               n_q;
	logic [NW-1:0]               p_q;
	logic [KW-1:0]               k_q;
	logic [KW-1:0]               c_q;
	logic signed [SAMPLE_W-1:0]  mn_q, mx_q, smp_q;
	logic [EW-1:0]               best_err_q;
	logic [CW-1:0]               best_tag_q;
	logic                        init_q;
	logic                        reloc_q;
	logic [TW-1:0]               total_q;
	logic [TW-1:0]               lim_q;
	logic [ITER_W-1:0]           iters_q;
	logic                        neg_q;
	logic signed [CENT_W-1:0]    cent_q [MAX_CLUSTERS];
	logic signed [SW-1:0]        sum_q  [MAX_CLUSTERS];
	logic [NW-1:0]               size_q [MAX_CLUSTERS];
	logic                        rv_q;
	logic [TAG_W-1:0]            tag_q;
	logic [STATUS_W-1:0]         status_q;
	logic [ITER_W-1:0]           iter_out_q;
	logic                        last_q;

	// RAM ports
	logic                       smp_we, res_we;
	logic signed [SAMPLE_W-1:0] smp_rd;
	logic [CW-1:0]              tag_rd, tag_wd;
	logic [EW-1:0]              err_rd, err_wd;

	// shared divider
	div_ctl_t      div;
	logic [DW-1:0] div_dividend, div_quo;
	logic [VW-1:0] div_divisor;

	// combinational helpers
	logic                       in_acc;
	logic [NW-1:0]              n_new;
	logic [KW-1:0]              k_clamp;
	logic                       last_p, c_last, can_latch;
	logic signed [CENT_W-1:0]   cur_cent;
	logic signed [EW-1:0]       diff;
	logic [EW-1:0]              dist_abs;
	logic                       take;
	logic [SAMPLE_W:0]          span;
	logic signed [SW-1:0]       cur_sum;
	logic [SW-1:0]              abs_sum;
	logic                       stop;
	logic signed [EW-1:0]       seed_val;

	assign in_acc    = item_valid && item_ready;
	assign n_new     = (cnt_q < NW'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;
	assign last_p    = (p_q + 1'b1 == n_q);
	assign c_last    = (c_q + 1'b1 == k_q);
	assign can_latch = !rv_q || result_ready;

	always_comb begin
		if (nc_q == '0) begin
			k_clamp = KW'(1);
		end else if (32'(nc_q) > MAX_CLUSTERS) begin
			k_clamp = KW'(MAX_CLUSTERS);
		end else begin
			k_clamp = KW'(nc_q);
		end
	end

	// shared distance unit: |sample*256 - centroid| against the best so far
	always_comb begin
		cur_cent = cent_q[c_q[CW-1:0]];
		diff     = EW'($signed({smp_q, {FRAC_W{1'b0}}})) - EW'(cur_cent);
		dist_abs = diff[EW-1] ? EW'(-diff) : EW'(diff);
		take     = (init_q && c_q == '0) || (dist_abs < best_err_q);
	end

	// divider operands for seeding and for the mean update
	always_comb begin
		span     = (SAMPLE_W+1)'(mx_q) - (SAMPLE_W+1)'(mn_q);
		cur_sum  = sum_q[c_q[CW-1:0]];
		abs_sum  = cur_sum[SW-1] ? SW'(-cur_sum) : SW'(cur_sum);
		seed_val = EW'({mn_q, {FRAC_W{1'b0}}}) + EW'(div_quo[CENT_W:0]);
		if (st_q == ST_SEED) begin
			div_dividend = DW'({(SAMPLE_W+CW)'(span[SAMPLE_W-1:0])
				* (SAMPLE_W+CW)'(c_q[CW-1:0]), {FRAC_W{1'b0}}});
			div_divisor  = VW'(k_q - 1'b1);
		end else begin
			div_dividend = DW'({abs_sum[SW-2:0], {FRAC_W{1'b0}}});
			div_divisor  = VW'(size_q[c_q[CW-1:0]]);
		end
	end

	assign stop = !((total_q >= lim_q) && (iters_q < mi_q) && reloc_q);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD:   if (in_acc && is_last) st_d = (n_new < NW'(2)) ? ST_FEW : ST_MM_A;
			ST_MM_A:   st_d = ST_MM_D;
			ST_MM_D:   st_d = last_p ? ST_SEED : ST_MM_A;
			ST_SEED:   st_d = (k_q == KW'(1)) ? ST_ASG_A : ST_SEED_W;
			ST_SEED_W: if (div.done) st_d = c_last ? ST_ASG_A : ST_SEED;
			ST_ASG_A:  st_d = ST_ASG_L;
			ST_ASG_L:  st_d = ST_ASG_C;
			ST_ASG_C: begin
				if (c_last) st_d = !last_p ? ST_ASG_A : (init_q ? ST_CLR : ST_CHK);
			end
			ST_CLR:    st_d = ST_SUM_A;
			ST_SUM_A:  st_d = ST_SUM_D;
			ST_SUM_D:  st_d = last_p ? ST_MEAN : ST_SUM_A;
			ST_MEAN: begin
				if (c_q == k_q) st_d = ST_ASG_A;
				else if (size_q[c_q[CW-1:0]] != '0) st_d = ST_MEAN_W;
			end
			ST_MEAN_W: if (div.done) st_d = ST_MEAN;
			ST_CHK:    st_d = ST_DEC;
			ST_DEC:    st_d = stop ? ST_OUT_A : ST_CLR;
			ST_OUT_A:  st_d = ST_OUT_L;
			ST_OUT_L:  if (can_latch) st_d = last_p ? ST_LOAD : ST_OUT_A;
			ST_FEW:    if (can_latch) st_d = ST_LOAD;
			default:   st_d = ST_LOAD;
		endcase
	end

	// control outputs
	always_comb begin
		item_ready = (st_q == ST_LOAD);
		smp_we     = in_acc && (cnt_q < NW'(MAX_POINTS));
		res_we     = (st_q == ST_ASG_C) && c_last;
		tag_wd     = take ? c_q[CW-1:0] : best_tag_q;
		err_wd     = take ? dist_abs : best_err_q;
		div.start  = ((st_q == ST_SEED) && (k_q != KW'(1)))
			|| ((st_q == ST_MEAN) && (c_q != k_q) && (size_q[c_q[CW-1:0]] != '0));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			rv_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (in_acc) begin
				if (cnt_q < NW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			// empty the set once the run has handed off its final result
			if ((st_q == ST_OUT_L && can_latch && last_p) || (st_q == ST_FEW && can_latch)) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if ((st_q == ST_OUT_L || st_q == ST_FEW) && can_latch) rv_q <= 1'b1;
			else if (result_ready) rv_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_LOAD: begin
				if (in_acc && is_last) begin
					n_q     <= n_new;
					k_q     <= k_clamp;
					p_q     <= '0;
					iters_q <= '0;
				end
			end
			ST_MM_D: begin
				if (p_q == '0 || smp_rd < mn_q) mn_q <= smp_rd;
				if (p_q == '0 || smp_rd > mx_q) mx_q <= smp_rd;
				p_q <= last_p ? '0 : p_q + 1'b1;
				c_q <= '0;
			end
			ST_SEED: begin
				if (k_q == KW'(1)) begin
					cent_q[0] <= CENT_W'({mx_q, {FRAC_W{1'b0}}});
					init_q    <= 1'b1;
				end
			end
			ST_SEED_W: begin
				if (div.done) begin
					cent_q[c_q[CW-1:0]] <= CENT_W'(seed_val);
					c_q    <= c_q + 1'b1;
					init_q <= 1'b1;
				end
			end
			ST_ASG_L: begin
				smp_q      <= smp_rd;
				best_err_q <= err_rd;
				best_tag_q <= tag_rd;
				c_q        <= '0;
			end
			ST_ASG_C: begin
				if (take) begin
					best_err_q <= dist_abs;
					best_tag_q <= c_q[CW-1:0];
					if (!init_q) reloc_q <= 1'b1;
				end
				if (c_last) begin
					total_q <= total_q + TW'(err_wd);
					p_q     <= last_p ? '0 : p_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			ST_CLR: begin
				for (int i = 0; i < MAX_CLUSTERS; i++) begin
					sum_q[i]  <= '0;
					size_q[i] <= '0;
				end
				p_q <= '0;
			end
			ST_SUM_D: begin
				sum_q[tag_rd]  <= sum_q[tag_rd] + SW'(smp_rd);
				size_q[tag_rd] <= size_q[tag_rd] + 1'b1;
				p_q <= last_p ? '0 : p_q + 1'b1;
				c_q <= '0;
			end
			ST_MEAN: begin
				neg_q <= cur_sum[SW-1];
				if (c_q == k_q) begin
					init_q  <= 1'b0;
					reloc_q <= 1'b0;
					total_q <= '0;
					p_q     <= '0;
				end else if (size_q[c_q[CW-1:0]] == '0) begin
					c_q <= c_q + 1'b1;
				end
			end
			ST_MEAN_W: begin
				if (div.done) begin
					cent_q[c_q[CW-1:0]] <= neg_q ? CENT_W'(-div_quo[CENT_W-1:0])
						: CENT_W'(div_quo[CENT_W-1:0]);
					c_q <= c_q + 1'b1;
				end
			end
			ST_CHK: begin
				iters_q <= iters_q + 1'b1;
				lim_q   <= TW'(EW'(me_q) + 1'b1) * TW'(n_q);
			end
			ST_DEC: p_q <= '0;
			ST_OUT_L: begin
				if (can_latch) begin
					tag_q      <= TAG_W'(tag_rd);
					status_q   <= ovf_q ? STATUS_DROPPED : STATUS_OK;
					iter_out_q <= iters_q;
					last_q     <= last_p;
					p_q        <= p_q + 1'b1;
				end
			end
			ST_FEW: begin
				if (can_latch) begin
					tag_q      <= '0;
					status_q   <= STATUS_TOO_FEW;
					iter_out_q <= '0;
					last_q     <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = rv_q;
	assign tag          = tag_q;
	assign status       = status_q;
	assign iterations   = iter_out_q;
	assign last_tag     = last_q;

	// sample, tag and error stores
	kmc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_POINTS)) u_smp_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata (sample),
		.raddr (p_q[IW-1:0]),
		.rdata (smp_rd)
	);

	kmc_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_tag_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (p_q[IW-1:0]),
		.wdata (tag_wd),
		.raddr (p_q[IW-1:0]),
		.rdata (tag_rd)
	);

	kmc_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_err_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (p_q[IW-1:0]),
		.wdata (err_wd),
		.raddr (p_q[IW-1:0]),
		.rdata (err_rd)
	);

	kmc_div #(.DW(DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div.start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div.busy),
		.done     (div.done),
		.quotient (div_quo)
	);

	// checks
`include "kmeans_1d_clusterer_assert.svh"
	`KMC_ASSERT_IMPLY(a_div_idle, div.start, !div.busy, "divider started while busy")
	`KMC_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= NW'(MAX_POINTS), "sample count above capacity")
	`KMC_ASSERT_IMPLY(a_asg_range, st_q == ST_ASG_C, c_q < k_q, "centroid index out of range")

endmodule
